// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/pgrd_pkg.sv =====
// ----------------------------------------------------------------------------
// pgrd_pkg
// types and constants of the packed glyph run decoder
// ----------------------------------------------------------------------------
package pgrd_pkg;

    // opcodes
    localparam logic [7:0] OP_PAINT1      = 8'd64;
    localparam logic [7:0] OP_PAINT3      = 8'd66;
    localparam logic [7:0] OP_BOX_LONG    = 8'd67;
    localparam logic [7:0] OP_BOX_SHORT   = 8'd68;
    localparam logic [7:0] OP_END         = 8'd69;
    localparam logic [7:0] OP_SKIP0       = 8'd70;
    localparam logic [7:0] OP_SKIP1       = 8'd71;
    localparam logic [7:0] OP_SKIP3       = 8'd73;
    localparam logic [7:0] OP_NEWROW0     = 8'd74;
    localparam logic [7:0] OP_NEWROW_LAST = 8'd238;
    localparam logic [7:0] OP_XXX1        = 8'd239;
    localparam logic [7:0] OP_XXX4        = 8'd242;
    localparam logic [7:0] OP_YYY         = 8'd243;
    localparam logic [7:0] OP_NOOP        = 8'd244;

    // bytes dropped after a box opcode before its fields, and after OP_YYY
    localparam logic [31:0] BOX_LONG_SKIP  = 32'd8;
    localparam logic [31:0] BOX_SHORT_SKIP = 32'd1;
    localparam logic [31:0] YYY_SKIP       = 32'd4;

    // 34-bit signed position limits, held in 36 bits
    localparam logic signed [35:0] POS_MAX36 = 36'sd8589934591;
    localparam logic signed [35:0] POS_MIN36 = -36'sd8589934592;

    localparam int TDATA_W = 224;

    typedef enum logic [1:0] {
        KIND_BOX   = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        PH_BEFORE_BOX = 1'b0,
        PH_BODY       = 1'b1
    } phase_t;

    // packed from the top bit down, box_width in the lowest bits
    typedef struct packed {
        logic        outside_box;
        logic [23:0] run_length;
        logic [31:0] run_column;
        logic [31:0] run_row;
        logic [31:0] y_offset;
        logic [32:0] x_offset;
        logic [32:0] box_height;
        logic [32:0] box_width;
    } result_t;

    // signed difference clipped to 0 .. 2^32-1
    function automatic logic [31:0] sat_u32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v < 0)
        begin
            r = 32'd0;
        end
        else if (v[35:32] != 4'd0)
        begin
            r = 32'hFFFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/packed_glyph_run_decoder.sv =====
// ----------------------------------------------------------------------------
// packed_glyph_run_decoder
// a command word is held in the input register and its result word in the result register
// throughput: one command word per cycle while no result word is stalled; set by the
//   update of the parse and position registers between the input and result registers
// reset: asynchronous, clears parse state, positions and both valid flags
// ----------------------------------------------------------------------------
module packed_glyph_run_decoder
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // cmd_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // box_width, box_height, x_offset, y_offset, run_row, run_column,
    // run_length, outside_box, zero fill
    output logic [223:0] m_tdata,
    output logic [1:0]   m_tuser    // kind
);

    pgrd_pkg::phase_t       phase_reg, phase_next;
    logic [7:0]             op_reg, op_next;
    logic [2:0]             left_reg, left_next;
    logic [31:0]            acc_reg, acc_next;
    logic [1:0]             fidx_reg, fidx_next;
    logic [31:0]            skip_reg, skip_next;
    logic signed [31:0]     min_col_reg, min_col_next;
    logic signed [31:0]     max_col_reg, max_col_next;
    logic signed [31:0]     min_row_reg, min_row_next;
    logic signed [31:0]     max_row_reg, max_row_next;
    logic signed [33:0]     cur_col_reg, cur_col_next;
    logic signed [33:0]     cur_row_reg, cur_row_next;
    logic                   black_reg, black_next;

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg, out_valid_next;
    pgrd_pkg::kind_t        out_kind_reg;
    pgrd_pkg::result_t      out_data_reg;

    logic                   fire;
    logic                   res_valid;
    pgrd_pkg::kind_t        res_kind;
    pgrd_pkg::result_t      res_data;

    logic [7:0]             b;
    logic                   arg_path;
    logic [31:0]            acc_new;
    logic [23:0]            paint_d;
    logic signed [35:0]     col_ext, row_ext;
    logic signed [35:0]     min_col_ext, max_col_ext, min_row_ext, max_row_ext;
    logic signed [35:0]     col_sum, col_last;
    logic [33:0]            col_clamped;
    logic [24:0]            row_dec;
    logic signed [35:0]     row_diff;
    logic [33:0]            row_clamped;
    logic                   paint_outside;
    logic                   is_short;
    logic signed [31:0]     v;
    logic signed [31:0]     min_row_fin;
    logic signed [33:0]     box_w, box_h;
    logic [7:0]             newrow_off;

    // handshake
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};
    assign m_tuser  = out_kind_reg;

    // shared datapath
    assign b           = in_byte_reg;
    assign arg_path    = (left_reg != 3'd0);
    assign acc_new     = {acc_reg[23:0], b};
    assign paint_d     = arg_path ? acc_new[23:0] : {18'd0, b[5:0]};
    assign col_ext     = $signed({{2{cur_col_reg[33]}}, cur_col_reg});
    assign row_ext     = $signed({{2{cur_row_reg[33]}}, cur_row_reg});
    assign min_col_ext = $signed({{4{min_col_reg[31]}}, min_col_reg});
    assign max_col_ext = $signed({{4{max_col_reg[31]}}, max_col_reg});
    assign min_row_ext = $signed({{4{min_row_reg[31]}}, min_row_reg});
    assign max_row_ext = $signed({{4{max_row_reg[31]}}, max_row_reg});

    assign col_sum     = col_ext + $signed({12'd0, paint_d});
    assign col_last    = col_sum - 36'sd1;
    assign col_clamped = (col_sum > pgrd_pkg::POS_MAX36) ? pgrd_pkg::POS_MAX36[33:0]
                                                         : col_sum[33:0];
    assign row_dec     = arg_path ? ({1'b0, acc_new[23:0]} + 25'd1) : 25'd1;
    assign row_diff    = row_ext - $signed({11'd0, row_dec});
    assign row_clamped = (row_diff < pgrd_pkg::POS_MIN36) ? pgrd_pkg::POS_MIN36[33:0]
                                                          : row_diff[33:0];
    assign paint_outside = (row_ext < min_row_ext) || (row_ext > max_row_ext) ||
                           (col_ext < min_col_ext) || (col_last > max_col_ext);

    assign is_short    = (op_reg == pgrd_pkg::OP_BOX_SHORT);
    assign v           = $signed(acc_new);
    assign min_row_fin = is_short ? (v - min_row_reg) : min_row_reg;
    assign box_w       = $signed({{2{max_col_reg[31]}}, max_col_reg})
                       - $signed({{2{min_col_reg[31]}}, min_col_reg}) + 34'sd1;
    assign box_h       = $signed({{2{v[31]}}, v})
                       - $signed({{2{min_row_fin[31]}}, min_row_fin}) + 34'sd1;
    assign newrow_off  = b - pgrd_pkg::OP_NEWROW0;

    always_comb
    begin
        phase_next   = phase_reg;
        op_next      = op_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        fidx_next    = fidx_reg;
        skip_next    = skip_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        black_next   = black_reg;
        res_valid    = 1'b0;
        res_kind     = pgrd_pkg::KIND_BOX;
        res_data     = '0;

        if (fire)
        begin
            if (skip_reg != 32'd0)
            begin
                skip_next = skip_reg - 32'd1;
            end
            else if (arg_path)
            begin
                acc_next  = acc_new;
                left_next = left_reg - 3'd1;
                if (left_reg == 3'd1)
                begin
                    if (op_reg == pgrd_pkg::OP_BOX_LONG || is_short)
                    begin
                        case (fidx_reg)
                            2'd0:
                            begin
                                min_col_next = v;
                            end
                            2'd1:
                            begin
                                max_col_next = v;
                                if (is_short)
                                begin
                                    min_col_next = v - min_col_reg;
                                end
                            end
                            2'd2:
                            begin
                                min_row_next = v;
                            end
                            default:
                            begin
                                max_row_next = v;
                                min_row_next = min_row_fin;
                            end
                        endcase
                        if (fidx_reg != 2'd3)
                        begin
                            fidx_next = fidx_reg + 2'd1;
                            left_next = is_short ? 3'd1 : 3'd4;
                            acc_next  = 32'd0;
                        end
                        else
                        begin
                            fidx_next = 2'd0;
                            res_valid = 1'b1;
                            if (box_w < 0 || box_h < 0)
                            begin
                                // negative box
                                phase_next = pgrd_pkg::PH_BEFORE_BOX;
                                skip_next  = 32'd0;
                                left_next  = 3'd0;
                                res_kind   = pgrd_pkg::KIND_ERROR;
                            end
                            else
                            begin
                                res_kind            = pgrd_pkg::KIND_BOX;
                                res_data.box_width  = box_w[32:0];
                                res_data.box_height = box_h[32:0];
                                res_data.x_offset   = 33'd0 - {min_col_reg[31], min_col_reg};
                                res_data.y_offset   = v;
                                phase_next   = pgrd_pkg::PH_BODY;
                                cur_col_next = {{2{min_col_reg[31]}}, min_col_reg};
                                cur_row_next = {{2{v[31]}}, v};
                                black_next   = 1'b0;
                            end
                        end
                    end
                    else if (op_reg >= pgrd_pkg::OP_PAINT1 && op_reg <= pgrd_pkg::OP_PAINT3)
                    begin
                        if (black_reg && paint_d != 24'd0)
                        begin
                            res_valid            = 1'b1;
                            res_kind             = pgrd_pkg::KIND_RUN;
                            res_data.run_row     = pgrd_pkg::sat_u32(max_row_ext - row_ext);
                            res_data.run_column  = pgrd_pkg::sat_u32(col_ext - min_col_ext);
                            res_data.run_length  = paint_d;
                            res_data.outside_box = paint_outside;
                        end
                        cur_col_next = col_clamped;
                        black_next   = !black_reg;
                    end
                    else if (op_reg >= pgrd_pkg::OP_SKIP1 && op_reg <= pgrd_pkg::OP_SKIP3)
                    begin
                        cur_col_next = {{2{min_col_reg[31]}}, min_col_reg};
                        cur_row_next = row_clamped;
                        black_next   = 1'b0;
                    end
                    else
                    begin
                        // special command length
                        skip_next = acc_new;
                    end
                end
            end
            else if (b >= pgrd_pkg::OP_XXX1 && b <= pgrd_pkg::OP_XXX4)
            begin
                op_next   = b;
                left_next = 3'(b - (pgrd_pkg::OP_XXX1 - 8'd1));
                acc_next  = 32'd0;
            end
            else if (b == pgrd_pkg::OP_YYY)
            begin
                skip_next = pgrd_pkg::YYY_SKIP;
            end
            else if (b == pgrd_pkg::OP_NOOP)
            begin
                skip_next = skip_reg;
            end
            else if (phase_reg == pgrd_pkg::PH_BEFORE_BOX)
            begin
                if (b == pgrd_pkg::OP_BOX_LONG)
                begin
                    op_next   = b;
                    left_next = 3'd4;
                    acc_next  = 32'd0;
                    fidx_next = 2'd0;
                    skip_next = pgrd_pkg::BOX_LONG_SKIP;
                end
                else if (b == pgrd_pkg::OP_BOX_SHORT)
                begin
                    op_next   = b;
                    left_next = 3'd1;
                    acc_next  = 32'd0;
                    fidx_next = 2'd0;
                    skip_next = pgrd_pkg::BOX_SHORT_SKIP;
                end
                else
                begin
                    phase_next = pgrd_pkg::PH_BEFORE_BOX;
                    skip_next  = 32'd0;
                    left_next  = 3'd0;
                    fidx_next  = 2'd0;
                    res_valid  = 1'b1;
                    res_kind   = pgrd_pkg::KIND_ERROR;
                end
            end
            else if (b == 8'd0)
            begin
                black_next = !black_reg;
            end
            else if (b < pgrd_pkg::OP_PAINT1)
            begin
                if (black_reg)
                begin
                    res_valid            = 1'b1;
                    res_kind             = pgrd_pkg::KIND_RUN;
                    res_data.run_row     = pgrd_pkg::sat_u32(max_row_ext - row_ext);
                    res_data.run_column  = pgrd_pkg::sat_u32(col_ext - min_col_ext);
                    res_data.run_length  = paint_d;
                    res_data.outside_box = paint_outside;
                end
                cur_col_next = col_clamped;
                black_next   = !black_reg;
            end
            else if (b <= pgrd_pkg::OP_PAINT3)
            begin
                op_next   = b;
                left_next = 3'(b - (pgrd_pkg::OP_PAINT1 - 8'd1));
                acc_next  = 32'd0;
            end
            else if (b == pgrd_pkg::OP_END)
            begin
                phase_next = pgrd_pkg::PH_BEFORE_BOX;
                res_valid  = 1'b1;
                res_kind   = pgrd_pkg::KIND_END;
            end
            else if (b == pgrd_pkg::OP_SKIP0)
            begin
                cur_col_next = {{2{min_col_reg[31]}}, min_col_reg};
                cur_row_next = row_clamped;
                black_next   = 1'b0;
            end
            else if (b >= pgrd_pkg::OP_SKIP1 && b <= pgrd_pkg::OP_SKIP3)
            begin
                op_next   = b;
                left_next = 3'(b - (pgrd_pkg::OP_SKIP1 - 8'd1));
                acc_next  = 32'd0;
            end
            else if (b >= pgrd_pkg::OP_NEWROW0 && b <= pgrd_pkg::OP_NEWROW_LAST)
            begin
                cur_col_next = {{2{min_col_reg[31]}}, min_col_reg} + {26'd0, newrow_off};
                cur_row_next = row_clamped;
                black_next   = 1'b1;
            end
            else
            begin
                // box opcode in the body or unknown opcode
                phase_next = pgrd_pkg::PH_BEFORE_BOX;
                skip_next  = 32'd0;
                left_next  = 3'd0;
                fidx_next  = 2'd0;
                res_valid  = 1'b1;
                res_kind   = pgrd_pkg::KIND_ERROR;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire && res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pgrd_pkg::PH_BEFORE_BOX;
            op_reg        <= 8'd0;
            left_reg      <= 3'd0;
            acc_reg       <= 32'd0;
            fidx_reg      <= 2'd0;
            skip_reg      <= 32'd0;
            min_col_reg   <= 32'sd0;
            max_col_reg   <= 32'sd0;
            min_row_reg   <= 32'sd0;
            max_row_reg   <= 32'sd0;
            cur_col_reg   <= 34'sd0;
            cur_row_reg   <= 34'sd0;
            black_reg     <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            left_reg      <= left_next;
            acc_reg       <= acc_next;
            fidx_reg      <= fidx_next;
            skip_reg      <= skip_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            black_reg     <= black_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (fire && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_data_reg <= res_data;
        end
    end

endmodule

// ===== sv/pgrd_checker.sv =====
// ----------------------------------------------------------------------------
// pgrd_checker
// port-level checks on the result stream of the packed glyph run decoder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pgrd_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [7:0]   s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [pgrd_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]   m_tuser
);

    logic is_run;
    logic is_box;
    logic in_word;

    assign is_run  = m_tvalid && (m_tuser == pgrd_pkg::KIND_RUN);
    assign is_box  = m_tvalid && (m_tuser == pgrd_pkg::KIND_BOX);
    assign in_word = s_tvalid && s_tready && (s_tdata != 8'd0);

    // stalled result word holds
    `ASSERT_IMPLIES_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // only runs carry run fields, and non-run words keep their fill bits zero
    `ASSERT_IMPLIES(a_run_fields, clk, rst_n, m_tvalid && !is_run, m_tdata[223:131] == 93'd0)

    // only headers carry box fields
    `ASSERT_IMPLIES(a_box_fields, clk, rst_n, m_tvalid && !is_box && (in_word || !in_word), m_tdata[130:0] == 131'd0)

    // a run never has zero length
    `ASSERT_IMPLIES(a_run_len, clk, rst_n, is_run, m_tdata[218:195] != 24'd0)

endmodule

bind packed_glyph_run_decoder pgrd_checker u_pgrd_checker (.*);
